// ===== hdl/mlcf_pkg.sv =====
// Shared constants and types for the makefile line continuation filter.
`timescale 1ns / 1ps

package mlcf_pkg;

	localparam int LINE_BITS_DEF = 20;
	localparam int COL_BITS_DEF = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] CH_BS = 8'h5C;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_NUL = 8'h00;

	typedef enum logic [2:0] {
		MODE_NORMAL,
		MODE_HELD_BS,
		MODE_SKIP,
		MODE_COMMENT,
		MODE_COMMENT_BS
	} scan_mode_t;

	// Up to two results per item: an optional flushed record, then an optional main one.
	typedef struct packed {
		logic       a_valid;
		logic [7:0] a_char;
		logic       b_valid;
		logic [7:0] b_char;
		logic       b_end;
	} rec_ctl_t;

endpackage

// ===== hdl/mlcf_if.sv =====
// Valid/ready channel interfaces for input bytes and result items.
`timescale 1ns / 1ps

interface mlcf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       end_of_input;
	logic       command_mode;

	modport source (output valid, byte_in, end_of_input, command_mode, input ready);
	modport sink (input valid, byte_in, end_of_input, command_mode, output ready);
endinterface

interface mlcf_out_if #(
	parameter int LINE_BITS = mlcf_pkg::LINE_BITS_DEF,
	parameter int COL_BITS = mlcf_pkg::COL_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic [7:0]           char_out;
	logic                 is_end;
	logic [LINE_BITS-1:0] line_number;
	logic [COL_BITS-1:0]  column_number;
	logic                 last;

	modport source (output valid, char_out, is_end, line_number, column_number, last,
		input ready);
	modport sink (input valid, char_out, is_end, line_number, column_number, last,
		output ready);
endinterface

// ===== hdl/mlcf_front.sv =====
// Front end: accepts bytes, tracks scan mode, line and column, builds result records.
`timescale 1ns / 1ps

module mlcf_front #(
	parameter int LINE_BITS = mlcf_pkg::LINE_BITS_DEF,
	parameter int COL_BITS = mlcf_pkg::COL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  string_source,
	mlcf_in_if.sink               in_ch,
	input  logic                  full,
	output logic                  push,
	output mlcf_pkg::rec_ctl_t    ctl,
	output logic [LINE_BITS-1:0]  a_line,
	output logic [COL_BITS-1:0]   a_col,
	output logic [LINE_BITS-1:0]  b_line,
	output logic [COL_BITS-1:0]   b_col
);

	mlcf_pkg::scan_mode_t mode_q, mode_d;
	logic [LINE_BITS-1:0] line_q, line_d, line_inc;
	logic [COL_BITS-1:0]  col_q, col_d, col_inc;
	logic                 take;
	logic                 accept;
	logic [7:0]           b;
	logic                 cmd;

	assign in_ch.ready = !full;
	assign accept = in_ch.valid && in_ch.ready;
	assign b = in_ch.byte_in;
	assign cmd = in_ch.command_mode;
	assign line_inc = (line_q == '1) ? line_q : line_q + LINE_BITS'(1);
	assign col_inc = (col_q == '1) ? col_q : col_q + COL_BITS'(1);
	assign push = accept && (ctl.a_valid || ctl.b_valid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= mlcf_pkg::MODE_NORMAL;
			line_q <= LINE_BITS'(1);
			col_q <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			line_q <= line_d;
			col_q <= col_d;
		end
	end

	always_comb begin
		mode_d = mode_q;
		line_d = line_q;
		col_d = col_q;
		take = 1'b0;
		ctl = '0;
		a_line = line_q;
		a_col = col_q;
		b_line = line_q;
		b_col = col_q;
		if (in_ch.end_of_input) begin
			if (mode_q == mlcf_pkg::MODE_HELD_BS) begin
				ctl.a_valid = 1'b1;
				ctl.a_char = mlcf_pkg::CH_BS;
			end else if (mode_q == mlcf_pkg::MODE_SKIP) begin
				ctl.a_valid = 1'b1;
				ctl.a_char = mlcf_pkg::CH_SP;
			end
			ctl.b_valid = 1'b1;
			ctl.b_end = 1'b1;
			ctl.b_char = mlcf_pkg::CH_NUL;
			if (mode_q == mlcf_pkg::MODE_COMMENT || mode_q == mlcf_pkg::MODE_COMMENT_BS) begin
				b_col = col_q;
			end else begin
				b_col = col_inc;
			end
			mode_d = mlcf_pkg::MODE_NORMAL;
			line_d = LINE_BITS'(1);
			col_d = '0;
		end else begin
			unique case (mode_q) inside
				mlcf_pkg::MODE_HELD_BS: begin
					if (b == mlcf_pkg::CH_NL) begin
						line_d = line_inc;
						col_d = '0;
						mode_d = mlcf_pkg::MODE_SKIP;
					end else begin
						ctl.a_valid = 1'b1;
						ctl.a_char = mlcf_pkg::CH_BS;
						take = 1'b1;
					end
				end
				mlcf_pkg::MODE_SKIP: begin
					if (b == mlcf_pkg::CH_SP || b == mlcf_pkg::CH_TAB) begin
						col_d = col_inc;
					end else begin
						ctl.a_valid = 1'b1;
						ctl.a_char = mlcf_pkg::CH_SP;
						take = 1'b1;
					end
				end
				mlcf_pkg::MODE_COMMENT, mlcf_pkg::MODE_COMMENT_BS: begin
					if (b == mlcf_pkg::CH_NL) begin
						line_d = line_inc;
						col_d = '0;
						if (mode_q == mlcf_pkg::MODE_COMMENT) begin
							mode_d = mlcf_pkg::MODE_NORMAL;
							ctl.b_valid = 1'b1;
							ctl.b_char = mlcf_pkg::CH_NL;
							b_line = line_inc;
							b_col = '0;
						end else begin
							mode_d = mlcf_pkg::MODE_COMMENT;
						end
					end else if (b == mlcf_pkg::CH_BS) begin
						mode_d = mlcf_pkg::MODE_COMMENT_BS;
					end else begin
						mode_d = mlcf_pkg::MODE_COMMENT;
					end
				end
				default: begin
					take = 1'b1;
				end
			endcase
			if (take) begin
				mode_d = mlcf_pkg::MODE_NORMAL;
				col_d = col_inc;
				if (b == mlcf_pkg::CH_NL) begin
					line_d = line_inc;
					col_d = '0;
					ctl.b_valid = 1'b1;
					ctl.b_char = mlcf_pkg::CH_NL;
					b_line = line_inc;
					b_col = '0;
				end else if (b == mlcf_pkg::CH_BS && !cmd) begin
					mode_d = mlcf_pkg::MODE_HELD_BS;
				end else if (b == mlcf_pkg::CH_HASH && !cmd && !string_source) begin
					mode_d = mlcf_pkg::MODE_COMMENT;
				end else begin
					ctl.b_valid = 1'b1;
					ctl.b_char = b;
					b_col = col_inc;
				end
			end
		end
	end

	ap_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		line_q != '0)
		else $error("line counter reached zero");

	ap_end_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_ch.end_of_input) |=>
		(line_q == LINE_BITS'(1) && col_q == '0 && mode_q == mlcf_pkg::MODE_NORMAL))
		else $error("end of input did not restart counters");

	ap_mode_legal: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q <= mlcf_pkg::MODE_COMMENT_BS)
		else $error("scan mode out of range");

endmodule

// ===== hdl/mlcf_back.sv =====
// Back end: short record queue and serializer; one result per cycle unless stalled.
`timescale 1ns / 1ps

module mlcf_back #(
	parameter int LINE_BITS = mlcf_pkg::LINE_BITS_DEF,
	parameter int COL_BITS = mlcf_pkg::COL_BITS_DEF,
	parameter int DEPTH = mlcf_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  mlcf_pkg::rec_ctl_t   ctl,
	input  logic [LINE_BITS-1:0] a_line,
	input  logic [COL_BITS-1:0]  a_col,
	input  logic [LINE_BITS-1:0] b_line,
	input  logic [COL_BITS-1:0]  b_col,
	output logic                 full,
	mlcf_out_if.source           out_ch
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	mlcf_pkg::rec_ctl_t   ctl_q [DEPTH];
	logic [LINE_BITS-1:0] a_line_q [DEPTH];
	logic [COL_BITS-1:0]  a_col_q [DEPTH];
	logic [LINE_BITS-1:0] b_line_q [DEPTH];
	logic [COL_BITS-1:0]  b_col_q [DEPTH];

	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                phase_q;
	logic                show_a;
	logic                pop;
	logic                handshake;
	mlcf_pkg::rec_ctl_t  head;

	assign full = (count_q == CNT_BITS'(DEPTH));
	assign head = ctl_q[rd_ptr_q];
	assign show_a = !phase_q && head.a_valid;
	assign handshake = out_ch.valid && out_ch.ready;
	assign pop = handshake && !(show_a && head.b_valid);

	assign out_ch.valid = (count_q != '0);
	assign out_ch.char_out = show_a ? head.a_char : head.b_char;
	assign out_ch.is_end = show_a ? 1'b0 : head.b_end;
	assign out_ch.line_number = show_a ? a_line_q[rd_ptr_q] : b_line_q[rd_ptr_q];
	assign out_ch.column_number = show_a ? a_col_q[rd_ptr_q] : b_col_q[rd_ptr_q];
	assign out_ch.last = show_a ? !head.b_valid : 1'b1;

	always_ff @(posedge clk) begin
		if (push) begin
			ctl_q[wr_ptr_q] <= ctl;
			a_line_q[wr_ptr_q] <= a_line;
			a_col_q[wr_ptr_q] <= a_col;
			b_line_q[wr_ptr_q] <= b_line;
			b_col_q[wr_ptr_q] <= b_col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
			phase_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_BITS'(1);
				phase_q <= 1'b0;
			end else if (handshake) begin
				phase_q <= 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_BITS'(1);
			end
		end
	end

	ap_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("record pushed into full queue");

	ap_phase_has_second: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (count_q != '0) && head.a_valid && head.b_valid)
		else $error("second result pending without a two-result record");

	ap_last_pops: assert property (@(posedge clk) disable iff (!arst_n)
		(handshake && out_ch.last) |=> !phase_q)
		else $error("serializer phase not cleared after last result");

endmodule

// ===== hdl/makefile_line_continuation_filter.sv =====
// Top level of the makefile line continuation filter.
`timescale 1ns / 1ps

// Usage:
// in_ch carries one raw byte per item with end_of_input and command_mode;
// out_ch carries result items (char_out, is_end, line_number, column_number,
// last). One input item yields zero, one or two result items; last marks the
// final result of an item.
// cfg_we/cfg_data write string_source; write it only while the block is idle.
// A result enters the record queue when its item is taken; out_ch shows the
// queue head. One item per cycle is taken while each item yields at most one
// result and out_ch is ready; an item that flushes a held backslash or space
// delivers its two results one after the other. The rate is set by the front
// end mode and counter update and the back end one-result-per-cycle serializer.
// A two-entry record queue separates the two; in_ch.ready depends only on
// its fill level, so a stall on out_ch backs up into in_ch after two records.
// Reset: mode normal, line 1, column 0, string_source 0, queue empty.
module makefile_line_continuation_filter #(
	parameter int LINE_BITS = mlcf_pkg::LINE_BITS_DEF,
	parameter int COL_BITS = mlcf_pkg::COL_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_data,
	mlcf_in_if.sink    in_ch,
	mlcf_out_if.source out_ch
);

	logic                 string_source_q;
	logic                 push;
	logic                 full;
	mlcf_pkg::rec_ctl_t   ctl;
	logic [LINE_BITS-1:0] a_line, b_line;
	logic [COL_BITS-1:0]  a_col, b_col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			string_source_q <= 1'b0;
		end else if (cfg_we) begin
			string_source_q <= cfg_data;
		end
	end

	mlcf_front #(
		.LINE_BITS(LINE_BITS),
		.COL_BITS(COL_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.string_source(string_source_q),
		.in_ch(in_ch),
		.full(full),
		.push(push),
		.ctl(ctl),
		.a_line(a_line),
		.a_col(a_col),
		.b_line(b_line),
		.b_col(b_col)
	);

	mlcf_back #(
		.LINE_BITS(LINE_BITS),
		.COL_BITS(COL_BITS),
		.DEPTH(mlcf_pkg::QUEUE_DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.ctl(ctl),
		.a_line(a_line),
		.a_col(a_col),
		.b_line(b_line),
		.b_col(b_col),
		.full(full),
		.out_ch(out_ch)
	);

endmodule
